### hdl/polyline_arc_length_resampler_top_defines.svh
// Assertion macros used by the resampler back end.
`ifndef POLYLINE_ARC_LENGTH_RESAMPLER_TOP_DEFINES_SVH
`define POLYLINE_ARC_LENGTH_RESAMPLER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PALS_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
`define PALS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`else
`define PALS_ASSERT_ALWAYS(label, expr, msg)
`define PALS_ASSERT_IMPLY(label, ante, cons, msg)
`endif
`endif

### hdl/pals_pkg.sv
// Shared types and constants of the polyline resampler.
package pals_pkg;
   localparam int SEP_W       = 16;
   localparam int DIST_W      = 24;
   localparam int QUEUE_DEPTH = 2;

   localparam logic REG_POINT_SEPARATION = 1'b0;
   localparam logic REG_FILL_CORNERS     = 1'b1;

   localparam logic [SEP_W-1:0] SEP_RESET = 16'd256;

   typedef struct packed {
      logic starts;
      logic x_up;
      logic y_up;
      logic after_le0;
      logic after_ge0;
   } item_flags_type;
endpackage

### hdl/pals_front.sv
// Front end: accepts vertices, tracks the previous vertex and classifies each segment.
module pals_front #(
   parameter int C       = 12,
   parameter int ENTRY_W = 77
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [C-1:0]       req_vertex_x,
   input  logic [C-1:0]       req_vertex_y,
   input  logic               req_starts_line,
   input  logic               q_full,
   output logic               q_push,
   output logic [ENTRY_W-1:0] q_data
);
   logic [C-1:0] lvx_ff, lvx_in;
   logic [C-1:0] lvy_ff, lvy_in;
   logic [C-1:0] magx, magy;
   pals_pkg::item_flags_type flags;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      flags.starts    = req_starts_line;
      flags.x_up      = req_vertex_x >= lvx_ff;
      flags.y_up      = req_vertex_y >= lvy_ff;
      flags.after_le0 = req_vertex_y <= lvy_ff;
      flags.after_ge0 = req_vertex_y >= lvy_ff;
      magx = flags.x_up ? req_vertex_x - lvx_ff : lvx_ff - req_vertex_x;
      magy = flags.y_up ? req_vertex_y - lvy_ff : lvy_ff - req_vertex_y;
      lvx_in = q_push ? req_vertex_x : lvx_ff;
      lvy_in = q_push ? req_vertex_y : lvy_ff;
   end

   assign q_data = {flags, req_vertex_x, req_vertex_y, lvx_ff, lvy_ff, magx, magy};

   always_ff @(posedge clock) begin
      if (reset) begin
         lvx_ff <= '0;
         lvy_ff <= '0;
      end else begin
         lvx_ff <= lvx_in;
         lvy_ff <= lvy_in;
      end
   end
endmodule

### hdl/pals_queue.sv
// Short queue that decouples the front end from the point generator.
module pals_queue #(
   parameter int WIDTH = 77
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int DEPTH = pals_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = cnt_ff == CNT_W'(DEPTH);
   assign empty    = cnt_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? ((wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop ? ((rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_data;
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

### hdl/pals_div.sv
// Restoring divider that produces one quotient bit per cycle.
module pals_div #(
   parameter int NUM_W = 41,
   parameter int DEN_W = 21
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot,
   output logic [DEN_W-1:0] rem
);
   localparam int IT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in, quot_ff, quot_in;
   logic [DEN_W-1:0] den_ff, den_in, rem_ff, rem_in;
   logic [IT_W-1:0]  it_ff, it_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W:0]   trial;

   assign trial = {rem_ff, num_ff[NUM_W-1]};

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      it_in   = it_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         quot_in = '0;
         it_in   = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in  = DEN_W'(trial - {1'b0, den_ff});
            quot_in = {quot_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[DEN_W-1:0];
            quot_in = {quot_ff[NUM_W-2:0], 1'b0};
         end
         it_in = it_ff + 1'b1;
         if (it_ff == IT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      it_ff   <= it_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end
endmodule

### hdl/pals_back.sv
// Back end: measures each segment, walks it and emits the resampled points.
`include "polyline_arc_length_resampler_top_defines.svh"
module pals_back #(
   parameter int C       = 12,
   parameter int F       = 8,
   parameter int MAXP    = 64,
   parameter int ENTRY_W = 77
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   input  logic [ENTRY_W-1:0]         q_data,
   output logic                       q_pop,
   input  logic [pals_pkg::SEP_W-1:0] sep,
   input  logic                       fill_corners,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [C-1:0]               rsp_point_x,
   output logic [C-1:0]               rsp_point_y,
   output logic                       rsp_last_of_run,
   output logic                       rsp_truncated
);
   localparam int SEP_W  = pals_pkg::SEP_W;
   localparam int DIST_W = pals_pkg::DIST_W;
   localparam int Q_W    = C + F;
   localparam int ROOT_W = C + 1 + F;
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int DEN_W  = (ROOT_W > SEP_W) ? ROOT_W : SEP_W;
   localparam int WALK_W = ((DEN_W > DIST_W) ? DEN_W : DIST_W) + 1;
   localparam int NUM_W  = C + DEN_W + F;
   localparam int CNT_W  = $clog2(MAXP + 1);
   localparam int IT_W   = $clog2(ROOT_W);
   localparam int FL_W   = $bits(pals_pkg::item_flags_type);

   localparam logic [2:0] DIV_REM = 3'd0;
   localparam logic [2:0] DIV_X0  = 3'd1;
   localparam logic [2:0] DIV_XS  = 3'd2;
   localparam logic [2:0] DIV_Y0  = 3'd3;
   localparam logic [2:0] DIV_YS  = 3'd4;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_CORNER = 10'b0000000010,
      ST_SQ     = 10'b0000000100,
      ST_SUM    = 10'b0000001000,
      ST_ROOT   = 10'b0000010000,
      ST_CHECK  = 10'b0000100000,
      ST_MUL    = 10'b0001000000,
      ST_DSTART = 10'b0010000000,
      ST_DWAIT  = 10'b0100000000,
      ST_FIN    = 10'b1000000000
   } state_type;

   function automatic logic [C-1:0] pix(input logic [Q_W-1:0] q);
      logic [Q_W:0] s;
      s = {1'b0, q} + ((Q_W + 1)'(1) << (F - 1));
      return s[Q_W-1:F];
   endfunction

   state_type state_ff, state_in;
   logic walk_ff, walk_in;

   logic [ENTRY_W-1:0] entry_ff, entry_in;
   pals_pkg::item_flags_type fl, qfl;
   logic [C-1:0] lvx, lvy, magx, magy;

   logic [Q_W-1:0]    emx_ff, emx_in, emy_ff, emy_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic              npy_ff, npy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              cut_ff, cut_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [C-1:0]      pend_px_ff, pend_px_in, pend_py_ff, pend_py_in;

   logic [2*C-1:0]    sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ROOT_W+1:0] rem_ff, rem_in, rem_sh, trial;
   logic [IT_W-1:0]   it_ff, it_in;

   logic [C+ROOT_W-1:0] pxd_ff, pxd_in, pyd_ff, pyd_in;
   logic [C+SEP_W-1:0]  pxs_ff, pxs_in, pys_ff, pys_in;
   logic [2:0]          sel_ff, sel_in;
   logic [WALK_W-1:0]   wk_ff, wk_in, d_ext;
   logic [Q_W-1:0]      qx_ff, qx_in, qy_ff, qy_in, qsx_ff, qsx_in, qsy_ff, qsy_in;
   logic [DEN_W-1:0]    rx_ff, rx_in, ry_ff, ry_in, rsx_ff, rsx_in, rsy_ff, rsy_in;
   logic [DEN_W:0]      rxsum, rysum;

   logic                rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic                rsp_trunc_ff, rsp_trunc_in;
   logic [C-1:0]        rsp_px_ff, rsp_px_in, rsp_py_ff, rsp_py_in;

   logic [SEP_W-1:0]    sep_eff;
   logic [NUM_W-1:0]    div_num, div_quot;
   logic [DEN_W-1:0]    div_den, div_rem;
   logic                div_start, div_done;

   logic [Q_W-1:0]      cand_x, cand_y, ly_q;
   logic                cand_go, dup, need_push, slot_free, blocked, corner_hit, walk_le;
   logic                out_load, out_last, out_trunc;

   assign fl       = entry_ff[ENTRY_W-1 -: FL_W];
   assign lvx      = entry_ff[4*C-1 -: C];
   assign lvy      = entry_ff[3*C-1 -: C];
   assign magx     = entry_ff[2*C-1 -: C];
   assign magy     = entry_ff[C-1 -: C];
   assign qfl      = q_data[ENTRY_W-1 -: FL_W];
   assign sep_eff  = (sep == '0) ? SEP_W'(1) : sep;
   assign ly_q     = {lvy, {F{1'b0}}};
   assign corner_hit = fill_corners &&
      (((ly_q > emy_ff) && fl.after_le0) || ((ly_q < emy_ff) && fl.after_ge0));
   assign walk_le  = wk_ff <= WALK_W'(root_ff);
   assign d_ext    = WALK_W'(dist_ff);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cand_go = 1'b0;
      cand_x  = {lvx, {F{1'b0}}};
      cand_y  = ly_q;
      if (walk_ff) begin
         cand_go = walk_le && (cnt_ff < CNT_W'(MAXP));
         cand_x  = fl.x_up ? {lvx, {F{1'b0}}} + qx_ff : {lvx, {F{1'b0}}} - qx_ff;
         cand_y  = fl.y_up ? ly_q + qy_ff : ly_q - qy_ff;
      end else if (state_ff == ST_CORNER) begin
         cand_go = corner_hit && (cnt_ff < CNT_W'(MAXP));
      end
   end

   assign dup = !npy_ff && (pix(cand_x) == pix(emx_ff)) && (pix(cand_y) == pix(emy_ff));
   assign need_push = cand_go && !dup;
   assign blocked   = need_push && pend_valid_ff && !slot_free;

   assign rem_sh = {rem_ff[ROOT_W-1:0], rad_ff[RAD_W-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign rxsum  = {1'b0, rx_ff} + {1'b0, rsx_ff};
   assign rysum  = {1'b0, ry_ff} + {1'b0, rsy_ff};

   always_comb begin
      case (sel_ff)
         DIV_REM: begin
            div_num = NUM_W'(root_ff - d_ext[ROOT_W-1:0]);
            div_den = DEN_W'(sep_eff);
         end
         DIV_X0: begin
            div_num = NUM_W'({pxd_ff, {F{1'b0}}}) + NUM_W'(root_ff >> 1);
            div_den = DEN_W'(root_ff);
         end
         DIV_XS: begin
            div_num = NUM_W'({pxs_ff, {F{1'b0}}});
            div_den = DEN_W'(root_ff);
         end
         DIV_Y0: begin
            div_num = NUM_W'({pyd_ff, {F{1'b0}}}) + NUM_W'(root_ff >> 1);
            div_den = DEN_W'(root_ff);
         end
         default: begin
            div_num = NUM_W'({pys_ff, {F{1'b0}}});
            div_den = DEN_W'(root_ff);
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;   walk_in = walk_ff;   entry_in = entry_ff;
      emx_in = emx_ff;       emy_in = emy_ff;     dist_in = dist_ff;
      npy_in = npy_ff;       cnt_in = cnt_ff;     cut_in = cut_ff;
      pend_valid_in = pend_valid_ff;  pend_px_in = pend_px_ff;  pend_py_in = pend_py_ff;
      sqx_in = sqx_ff;  sqy_in = sqy_ff;  rad_in = rad_ff;  root_in = root_ff;
      rem_in = rem_ff;  it_in = it_ff;
      pxd_in = pxd_ff;  pyd_in = pyd_ff;  pxs_in = pxs_ff;  pys_in = pys_ff;
      sel_in = sel_ff;  wk_in = wk_ff;
      qx_in = qx_ff;  qy_in = qy_ff;  qsx_in = qsx_ff;  qsy_in = qsy_ff;
      rx_in = rx_ff;  ry_in = ry_ff;  rsx_in = rsx_ff;  rsy_in = rsy_ff;
      q_pop = 1'b0;  div_start = 1'b0;
      out_load = 1'b0;  out_last = 1'b0;  out_trunc = 1'b0;

      if (need_push && !blocked) begin
         if (pend_valid_ff) out_load = 1'b1;
         pend_valid_in = 1'b1;
         pend_px_in    = pix(cand_x);
         pend_py_in    = pix(cand_y);
         emx_in        = cand_x;
         emy_in        = cand_y;
         npy_in        = 1'b0;
         cnt_in        = cnt_ff + 1'b1;
      end

      if (walk_ff) begin
         if (walk_le) begin
            if (cnt_ff >= CNT_W'(MAXP)) begin
               cut_in   = 1'b1;
               walk_in  = 1'b0;
               state_in = ST_FIN;
            end else if (!blocked) begin
               wk_in = wk_ff + WALK_W'(sep_eff);
               if (rxsum >= {1'b0, DEN_W'(root_ff)}) begin
                  rx_in = DEN_W'(rxsum - {1'b0, DEN_W'(root_ff)});
                  qx_in = qx_ff + qsx_ff + 1'b1;
               end else begin
                  rx_in = rxsum[DEN_W-1:0];
                  qx_in = qx_ff + qsx_ff;
               end
               if (rysum >= {1'b0, DEN_W'(root_ff)}) begin
                  ry_in = DEN_W'(rysum - {1'b0, DEN_W'(root_ff)});
                  qy_in = qy_ff + qsy_ff + 1'b1;
               end else begin
                  ry_in = rysum[DEN_W-1:0];
                  qy_in = qy_ff + qsy_ff;
               end
            end
         end else begin
            walk_in  = 1'b0;
            state_in = ST_FIN;
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  q_pop    = 1'b1;
                  entry_in = q_data;
                  if (qfl.starts) begin
                     emx_in  = {q_data[6*C-1 -: C], {F{1'b0}}};
                     emy_in  = {q_data[5*C-1 -: C], {F{1'b0}}};
                     dist_in = '0;
                     npy_in  = 1'b1;
                  end else begin
                     cnt_in   = '0;
                     cut_in   = 1'b0;
                     state_in = ST_CORNER;
                  end
               end
            end
            ST_CORNER: begin
               if (!blocked) begin
                  if (corner_hit) dist_in = '0;
                  state_in = ST_SQ;
               end
            end
            ST_SQ: begin
               sqx_in   = (2*C)'(magx) * (2*C)'(magx);
               sqy_in   = (2*C)'(magy) * (2*C)'(magy);
               state_in = ST_SUM;
            end
            ST_SUM: begin
               rad_in   = RAD_W'({({1'b0, sqx_ff} + {1'b0, sqy_ff}), {(2*F){1'b0}}});
               root_in  = '0;
               rem_in   = '0;
               it_in    = '0;
               state_in = ST_ROOT;
            end
            ST_ROOT: begin
               rad_in = {rad_ff[RAD_W-3:0], 2'b00};
               if (rem_sh >= trial) begin
                  rem_in  = rem_sh - trial;
                  root_in = {root_ff[ROOT_W-2:0], 1'b1};
               end else begin
                  rem_in  = rem_sh;
                  root_in = {root_ff[ROOT_W-2:0], 1'b0};
               end
               it_in = it_ff + 1'b1;
               if (it_ff == IT_W'(ROOT_W - 1)) state_in = ST_CHECK;
            end
            ST_CHECK: begin
               if (root_ff == '0) begin
                  state_in = ST_FIN;
               end else if (d_ext > WALK_W'(root_ff)) begin
                  dist_in  = DIST_W'(d_ext - WALK_W'(root_ff));
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_MUL;
               end
            end
            ST_MUL: begin
               pxd_in   = (C+ROOT_W)'(magx) * (C+ROOT_W)'(d_ext[ROOT_W-1:0]);
               pyd_in   = (C+ROOT_W)'(magy) * (C+ROOT_W)'(d_ext[ROOT_W-1:0]);
               pxs_in   = (C+SEP_W)'(magx) * (C+SEP_W)'(sep_eff);
               pys_in   = (C+SEP_W)'(magy) * (C+SEP_W)'(sep_eff);
               wk_in    = d_ext;
               sel_in   = DIV_REM;
               state_in = ST_DSTART;
            end
            ST_DSTART: begin
               div_start = 1'b1;
               state_in  = ST_DWAIT;
            end
            ST_DWAIT: begin
               if (div_done) begin
                  case (sel_ff)
                     DIV_REM: dist_in = DIST_W'(sep_eff - SEP_W'(div_rem));
                     DIV_X0: begin
                        qx_in = div_quot[Q_W-1:0];
                        rx_in = div_rem;
                     end
                     DIV_XS: begin
                        qsx_in = div_quot[Q_W-1:0];
                        rsx_in = div_rem;
                     end
                     DIV_Y0: begin
                        qy_in = div_quot[Q_W-1:0];
                        ry_in = div_rem;
                     end
                     default: begin
                        qsy_in = div_quot[Q_W-1:0];
                        rsy_in = div_rem;
                     end
                  endcase
                  if (sel_ff == DIV_YS) begin
                     walk_in = 1'b1;
                  end else begin
                     sel_in   = sel_ff + 1'b1;
                     state_in = ST_DSTART;
                  end
               end
            end
            ST_FIN: begin
               if (pend_valid_ff) begin
                  if (slot_free) begin
                     out_load      = 1'b1;
                     out_last      = 1'b1;
                     out_trunc     = cut_ff;
                     pend_valid_in = 1'b0;
                     state_in      = ST_IDLE;
                  end
               end else begin
                  state_in = ST_IDLE;
               end
            end
            default: state_in = ST_IDLE;
         endcase
      end

      rsp_px_in    = out_load ? pend_px_ff : rsp_px_ff;
      rsp_py_in    = out_load ? pend_py_ff : rsp_py_ff;
      rsp_last_in  = out_load ? out_last : rsp_last_ff;
      rsp_trunc_in = out_load ? out_trunc : rsp_trunc_ff;
      if (out_load) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   pals_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(div_den),
      .done(div_done), .quot(div_quot), .rem(div_rem)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_x     = rsp_px_ff;
   assign rsp_point_y     = rsp_py_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_truncated   = rsp_trunc_ff;

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;   pend_px_ff <= pend_px_in;  pend_py_ff <= pend_py_in;
      sqx_ff <= sqx_in;  sqy_ff <= sqy_in;  rad_ff <= rad_in;  root_ff <= root_in;
      rem_ff <= rem_in;  it_ff <= it_in;
      pxd_ff <= pxd_in;  pyd_ff <= pyd_in;  pxs_ff <= pxs_in;  pys_ff <= pys_in;
      sel_ff <= sel_in;  wk_ff <= wk_in;
      qx_ff <= qx_in;  qy_ff <= qy_in;  qsx_ff <= qsx_in;  qsy_ff <= qsy_in;
      rx_ff <= rx_in;  ry_ff <= ry_in;  rsx_ff <= rsx_in;  rsy_ff <= rsy_in;
      rsp_px_ff <= rsp_px_in;  rsp_py_ff <= rsp_py_in;
      rsp_last_ff <= rsp_last_in;  rsp_trunc_ff <= rsp_trunc_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         walk_ff       <= 1'b0;
         emx_ff        <= '0;
         emy_ff        <= '0;
         dist_ff       <= '0;
         npy_ff        <= 1'b1;
         cnt_ff        <= '0;
         cut_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         walk_ff       <= walk_in;
         emx_ff        <= emx_in;
         emy_ff        <= emy_in;
         dist_ff       <= dist_in;
         npy_ff        <= npy_in;
         cnt_ff        <= cnt_in;
         cut_ff        <= cut_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   `PALS_ASSERT_ALWAYS(a_cap, cnt_ff <= CNT_W'(MAXP), "point count exceeds the per-vertex cap")
   `PALS_ASSERT_IMPLY(a_slot, out_load, slot_free, "output register overwritten while stalled")
   `PALS_ASSERT_IMPLY(a_trunc, rsp_valid_ff && rsp_trunc_ff, rsp_last_ff, "truncated without last")
   `PALS_ASSERT_IMPLY(a_idle, state_ff == ST_IDLE && !walk_ff, !pend_valid_ff, "point left pending")
endmodule

### hdl/polyline_arc_length_resampler_top.sv
// Top level of the polyline equal arc length resampler.
// Vertices enter on the req_ channel; a transfer happens when req_valid is high
// and req_stall is low. A vertex with req_starts_line set only sets the start
// point. Every other vertex ends a segment, which is measured with a bit-serial
// square root and prepared with five divisions on one shared restoring divider.
// Points then leave on the rsp_ channel at one per cycle while rsp_stall is low,
// at most MAX_POINTS_PER_VERTEX per vertex, the final one flagged with
// rsp_last_of_run and, if the cap cut the run short, rsp_truncated.
// A two-entry queue lets new vertices be taken while a segment is worked on.
// When rsp_stall is high the finished point is held and the walk pauses.
// csr_ writes set the point separation (Q8.8) and corner filling; write them
// only while the block is idle. Reset is synchronous and returns the control
// state and the registers to their defaults; the first segment starts at (0,0).
module polyline_arc_length_resampler_top #(
   parameter int COORD_BITS            = 12,
   parameter int FRAC_BITS             = 8,
   parameter int MAX_POINTS_PER_VERTEX = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [COORD_BITS-1:0]      req_vertex_x,
   input  logic [COORD_BITS-1:0]      req_vertex_y,
   input  logic                       req_starts_line,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [COORD_BITS-1:0]      rsp_point_x,
   output logic [COORD_BITS-1:0]      rsp_point_y,
   output logic                       rsp_last_of_run,
   output logic                       rsp_truncated,
   input  logic                       csr_write,
   input  logic                       csr_index,
   input  logic [pals_pkg::SEP_W-1:0] csr_wdata
);
   localparam int ENTRY_W = $bits(pals_pkg::item_flags_type) + 6 * COORD_BITS;

   logic [pals_pkg::SEP_W-1:0] sep_ff, sep_in;
   logic                       fill_ff, fill_in;
   logic                       q_push, q_full, q_pop, q_empty;
   logic [ENTRY_W-1:0]         q_wdata, q_rdata;

   always_comb begin
      sep_in  = sep_ff;
      fill_in = fill_ff;
      if (csr_write) begin
         unique case (csr_index)
            pals_pkg::REG_POINT_SEPARATION: sep_in = csr_wdata;
            pals_pkg::REG_FILL_CORNERS:     fill_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff  <= pals_pkg::SEP_RESET;
         fill_ff <= 1'b0;
      end else begin
         sep_ff  <= sep_in;
         fill_ff <= fill_in;
      end
   end

   pals_front #(.C(COORD_BITS), .ENTRY_W(ENTRY_W)) u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_vertex_x(req_vertex_x), .req_vertex_y(req_vertex_y),
      .req_starts_line(req_starts_line), .q_full(q_full), .q_push(q_push), .q_data(q_wdata)
   );

   pals_queue #(.WIDTH(ENTRY_W)) u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_wdata), .full(q_full),
      .pop(q_pop), .pop_data(q_rdata), .empty(q_empty)
   );

   pals_back #(
      .C(COORD_BITS), .F(FRAC_BITS), .MAXP(MAX_POINTS_PER_VERTEX), .ENTRY_W(ENTRY_W)
   ) u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .q_data(q_rdata), .q_pop(q_pop),
      .sep(sep_ff), .fill_corners(fill_ff), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_point_x(rsp_point_x), .rsp_point_y(rsp_point_y),
      .rsp_last_of_run(rsp_last_of_run), .rsp_truncated(rsp_truncated)
   );
endmodule
